// File: hw/rtl/saes_pkg.sv
// Shared types, tables and round functions for the S-AES 16-bit cipher core.
// Used by saes_key_sched and simplified_aes_block_cipher_core; no dependencies.
package saes_pkg;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [7:0] RC_ONE = 8'h80;
  localparam logic [7:0] RC_TWO = 8'h30;

  localparam logic [3:0] FWD_SBOX [16] = '{4'd9, 4'd4, 4'd10, 4'd11, 4'd13, 4'd1, 4'd8, 4'd5,
                                           4'd6, 4'd2, 4'd0, 4'd3, 4'd12, 4'd14, 4'd15, 4'd7};
  localparam logic [3:0] INV_SBOX [16] = '{4'd10, 4'd5, 4'd9, 4'd11, 4'd1, 4'd7, 4'd8, 4'd15,
                                           4'd6, 4'd0, 4'd2, 4'd3, 4'd12, 4'd4, 4'd13, 4'd14};
  // GF(16) mod x^4+x+1 constant multiplies
  localparam logic [3:0] GF_X2 [16] = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14,
                                        4'd3, 4'd1, 4'd7, 4'd5, 4'd11, 4'd9, 4'd15, 4'd13};
  localparam logic [3:0] GF_X4 [16] = '{4'd0, 4'd4, 4'd8, 4'd12, 4'd3, 4'd7, 4'd11, 4'd15,
                                        4'd6, 4'd2, 4'd14, 4'd10, 4'd5, 4'd1, 4'd13, 4'd9};
  localparam logic [3:0] GF_X9 [16] = '{4'd0, 4'd9, 4'd1, 4'd8, 4'd2, 4'd11, 4'd3, 4'd10,
                                        4'd4, 4'd13, 4'd5, 4'd12, 4'd6, 4'd15, 4'd7, 4'd14};

  typedef struct packed {
    logic [15:0] k0;
    logic [15:0] k1;
    logic [15:0] k2;
  } round_keys_t;

  function automatic logic [15:0] sub_fwd(input logic [15:0] v);
    return {FWD_SBOX[v[15:12]], FWD_SBOX[v[11:8]], FWD_SBOX[v[7:4]], FWD_SBOX[v[3:0]]};
  endfunction

  function automatic logic [15:0] sub_inv(input logic [15:0] v);
    return {INV_SBOX[v[15:12]], INV_SBOX[v[11:8]], INV_SBOX[v[7:4]], INV_SBOX[v[3:0]]};
  endfunction

  // swap n1 and n3
  function automatic logic [15:0] nib_row_swap(input logic [15:0] v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic logic [15:0] mix_fwd(input logic [15:0] v);
    return {v[15:12] ^ GF_X4[v[11:8]], GF_X4[v[15:12]] ^ v[11:8],
            v[7:4] ^ GF_X4[v[3:0]], GF_X4[v[7:4]] ^ v[3:0]};
  endfunction

  function automatic logic [15:0] mix_inv(input logic [15:0] v);
    return {GF_X9[v[15:12]] ^ GF_X2[v[11:8]], GF_X2[v[15:12]] ^ GF_X9[v[11:8]],
            GF_X9[v[7:4]] ^ GF_X2[v[3:0]], GF_X2[v[7:4]] ^ GF_X9[v[3:0]]};
  endfunction

  // SubNib(RotNib(w))
  function automatic logic [7:0] g_word(input logic [7:0] w);
    return {FWD_SBOX[w[3:0]], FWD_SBOX[w[7:4]]};
  endfunction

  function automatic round_keys_t expand_key(input logic [15:0] key);
    round_keys_t rk;
    logic [7:0] w2, w3, w4, w5;
    w2 = key[15:8] ^ RC_ONE ^ g_word(key[7:0]);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ RC_TWO ^ g_word(w3);
    w5 = w4 ^ w3;
    rk.k0 = key;
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

  function automatic logic [15:0] encrypt(input logic [15:0] blk, input round_keys_t rk);
    logic [15:0] s;
    s = blk ^ rk.k0;
    s = mix_fwd(nib_row_swap(sub_fwd(s))) ^ rk.k1;
    s = nib_row_swap(sub_fwd(s)) ^ rk.k2;
    return s;
  endfunction

  function automatic logic [15:0] decrypt(input logic [15:0] blk, input round_keys_t rk);
    logic [15:0] s;
    s = blk ^ rk.k2;
    s = sub_inv(nib_row_swap(s)) ^ rk.k1;
    s = mix_inv(s);
    s = sub_inv(nib_row_swap(s)) ^ rk.k0;
    return s;
  endfunction

endpackage

// File: hw/rtl/saes_key_sched.sv
// Key register and registered round key expansion for the S-AES core.
// Depends on saes_pkg.
module saes_key_sched import saes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_cipher_key,
  output round_keys_t round_keys
);

  round_keys_t rk_r, rk_nxt;

  // expansion is done once per key write, not per word
  always_comb begin
    rk_nxt = rk_r;
    if (cfg_valid) begin
      rk_nxt = expand_key(cfg_cipher_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= expand_key(16'h0000);
    end else begin
      rk_r <= rk_nxt;
    end
  end

  assign round_keys = rk_r;

`ifndef NO_ASSERTIONS
  a_rk_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    rk_r == expand_key(rk_r.k0))
    else $error("round keys do not match key register");
  a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> rk_r.k0 == $past(cfg_cipher_key))
    else $error("key write lost");
  a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(rk_r))
    else $error("key changed without write");
`endif

endmodule

// File: hw/rtl/simplified_aes_block_cipher_core.sv
// Top level of the S-AES 16-bit block cipher core.
// Depends on saes_pkg and saes_key_sched.
//
// Usage:
//   Input channel: drive in_opcode (0 encrypt, 1 decrypt) and in_data_block
//   with start high; the word is taken at a rising edge where busy is low.
//   busy is always low, so a word may be presented every cycle.
//   Result channel: out_valid is high for exactly one cycle with
//   out_result_block; the receiver cannot stall and must take it then.
//   Configuration: cfg_cipher_key is written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. Write only while no word is in flight.
//   The new key applies to words taken after the write.
// Timing:
//   A word passes through one input register, the full two-round cipher in
//   one combinational stage, and one result register.
//   Throughput is one word per cycle.
// Reset:
//   rst_n is synchronous, active low; it clears the pipeline valids and sets
//   the key to zero. No word is lost or invented across reset release.
module simplified_aes_block_cipher_core import saes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_data_block,
  output logic        out_valid,
  output logic [15:0] out_result_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_cipher_key
);

  round_keys_t rk;

  logic        in_vld_r;
  logic        op_r;
  logic [15:0] blk_r;
  logic        out_vld_r;
  logic [15:0] res_r, res_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  saes_key_sched u_key_sched (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid & cfg_ready),
    .cfg_cipher_key(cfg_cipher_key),
    .round_keys    (rk)
  );

  always_comb begin
    case (op_r)
      OP_ENCRYPT: res_nxt = encrypt(blk_r, rk);
      OP_DECRYPT: res_nxt = decrypt(blk_r, rk);
      default:    res_nxt = encrypt(blk_r, rk);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start & ~busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      op_r  <= in_opcode;
      blk_r <= in_data_block;
    end
    res_r <= res_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_result_block = res_r;

`ifndef NO_ASSERTIONS
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_vld_r)
    else $error("accepted word produced no result");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_vld_r)
    else $error("result strobe without accepted word");
  a_enc_roundtrip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && op_r == OP_ENCRYPT) |=> decrypt(res_r, $past(rk)) == $past(blk_r))
    else $error("encrypt result does not decrypt back");
  a_dec_roundtrip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && op_r == OP_DECRYPT) |=> encrypt(res_r, $past(rk)) == $past(blk_r))
    else $error("decrypt result does not encrypt back");
`endif

endmodule
